[hw/rtl/ctldc_pkg.sv]
// Package for the two-loop crane controller: field widths, register indexes,
// Q16.16 scale constants and datapath widths. No dependencies.
`timescale 1ns / 1ps

package ctldc_pkg;

    // Field widths.
    localparam int REF_W   = 9;
    localparam int COUNT_W = 16;
    localparam int GAIN_W  = 32;
    localparam int DRIVE_W = 20;
    localparam int CFG_IDX_W = 3;

    // Shared multiplier operands and the wide accumulator.
    localparam int OPND_W = 33;
    localparam int PROD_W = 2 * OPND_W;

    typedef logic [CFG_IDX_W-1:0]        t_cfg_idx;
    typedef logic signed [GAIN_W-1:0]    t_q16;
    typedef logic signed [OPND_W-1:0]    t_opnd;
    typedef logic signed [PROD_W-1:0]    t_wide;
    typedef logic signed [DRIVE_W-1:0]   t_drive;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_GAIN_OUT_PREV  = 3'd0;
    localparam t_cfg_idx CFG_GAIN_OUT_PREV2 = 3'd1;
    localparam t_cfg_idx CFG_GAIN_ERR_NOW   = 3'd2;
    localparam t_cfg_idx CFG_GAIN_ERR_PREV  = 3'd3;
    localparam t_cfg_idx CFG_GAIN_ERR_PREV2 = 3'd4;
    localparam t_cfg_idx CFG_GAIN_PENDULUM  = 3'd5;

    // Q16.16 constants: unit conversions and loop scales.
    localparam t_opnd K_DEG2RAD  = 33'sd1144;
    localparam t_opnd K_ARM2RAD  = 33'sd1430;
    localparam t_opnd K_PEN2RAD  = 33'sd206;
    localparam t_opnd K_ERRSCALE = 33'sd3277;
    localparam t_opnd K_ARMSCALE = 33'sd58982;
    localparam t_opnd K_PENSCALE = 33'sd98304;

    // Limits.
    localparam t_wide  K_HALF      = 66'sd32768;
    localparam t_wide  K_LIMIT     = 66'sd327680;
    localparam t_wide  K_SUM_LIMIT = 66'sd1099511627776;
    localparam t_wide  K_INT32_MAX = 66'sd2147483647;
    localparam t_wide  K_INT32_MIN = -66'sd2147483648;
    localparam t_drive DRIVE_MAX   = 20'sd327680;
    localparam t_drive DRIVE_MIN   = -20'sd327680;

endpackage

[hw/rtl/ctldc_in_if.sv]
// Input channel of the crane controller: one control tick per transaction.
// Depends on ctldc_pkg for the field widths.
`timescale 1ns / 1ps

interface ctldc_in_if;
    import ctldc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [REF_W-1:0]   ref_angle_deg;
    logic signed [COUNT_W-1:0] arm_count;
    logic signed [COUNT_W-1:0] pendulum_count;

    modport source (output valid, output ref_angle_deg, output arm_count,
                    output pendulum_count, input ready);
    modport sink (input valid, input ref_angle_deg, input arm_count,
                  input pendulum_count, output ready);
endinterface

[hw/rtl/ctldc_out_if.sv]
// Output channel of the crane controller: one drive value per transaction.
// Depends on ctldc_pkg for the field widths.
`timescale 1ns / 1ps

interface ctldc_out_if;
    import ctldc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;
    logic                      clamped;

    modport source (output valid, output drive, output clamped, input ready);
    modport sink (input valid, input drive, input clamped, output ready);
endinterface

[hw/rtl/crane_two_loop_difference_controller.sv]
// Two-loop crane controller: arm difference equation plus pendulum P loop.
// Depends on ctldc_pkg, ctldc_in_if and ctldc_out_if.
`timescale 1ns / 1ps

// One input transaction (reference angle and both encoder counts) yields one
// drive value, written to the output register by the final step. The block
// is ready only in its idle state, so it takes no new input before the last
// one has gone through the sequencer. It steps one 33x33 signed multiplier,
// registered, and one wide accumulator through eighteen sequencer steps, with
// the multiply of one step overlapping the accumulate of the one before. The
// next input is taken as soon as the sequencer is idle, even while the last
// drive value still waits in the output register; the final step waits only
// if that register is still full. Gains are Q16.16; the user must write them
// via the config port while the block is idle, which it does not enforce.
// Arm loop output saturates to 32 bits; drive is clamped to plus or minus 5.

module crane_two_loop_difference_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  ctldc_pkg::t_cfg_idx  i_cfg_idx,
    input  ctldc_pkg::t_q16      i_cfg_data,
    ctldc_in_if.sink             i_in,
    ctldc_out_if.source          o_out
);
    import ctldc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_REF,
        ST_ARM,
        ST_PEN,
        ST_ERR_ARM,
        ST_ERR_PEN,
        ST_T_OP,
        ST_T_OP2,
        ST_T_EN,
        ST_T_EP,
        ST_T_EP2,
        ST_PEN_P,
        ST_SCALE_HI,
        ST_SCALE_LO,
        ST_PSCALE_HI,
        ST_PSCALE_LO,
        ST_U2_ACC,
        ST_SUM,
        ST_DONE
    } t_state;

    t_state r_state;

    // Gains.
    t_q16 r_gain_out_prev, r_gain_out_prev2, r_gain_err_now;
    t_q16 r_gain_err_prev, r_gain_err_prev2, r_gain_pendulum;

    // Loop history.
    t_q16 r_arm_err_prev, r_arm_err_prev2, r_arm_out_prev, r_arm_out_prev2;

    // Captured inputs and working values.
    logic signed [REF_W-1:0]   r_ref;
    logic signed [COUNT_W-1:0] r_arm;
    logic signed [COUNT_W-1:0] r_pen;
    t_opnd                     r_t;
    t_q16                      r_e_arm;
    t_q16                      r_e_pen;
    logic signed [34:0]        r_p;
    t_q16                      r_u1;
    t_wide                     r_acc;
    t_wide                     r_prod;

    // Output register.
    logic   r_out_valid;
    t_drive r_drive;
    logic   r_clamped;

    t_opnd w_a, w_b;
    t_wide w_rnd_prod, w_rnd_acc, w_neg_acc;
    logic signed [41:0] w_sum_sat;
    logic w_out_free;

    // Q16.16 rounding: to nearest, ties toward plus infinity.
    function automatic t_wide f_round(input t_wide x);
        t_wide t;
        t = x + K_HALF;
        return t >>> 16;
    endfunction

    assign w_rnd_prod = f_round(r_prod);
    assign w_rnd_acc  = f_round(r_acc);
    assign w_neg_acc  = -r_acc;
    assign w_out_free = !r_out_valid || o_out.ready;

    // Limit the arm loop sum to plus or minus 2^40 before scaling.
    always_comb begin
        if (r_acc > K_SUM_LIMIT) begin
            w_sum_sat = K_SUM_LIMIT[41:0];
        end else if (r_acc < -K_SUM_LIMIT) begin
            w_sum_sat = -K_SUM_LIMIT[41:0];
        end else begin
            w_sum_sat = r_acc[41:0];
        end
    end

    // Operand select for the shared multiplier.
    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_state)
            ST_REF: begin
                w_a = OPND_W'(r_ref);
                w_b = K_DEG2RAD;
            end
            ST_ARM: begin
                w_a = OPND_W'(r_arm);
                w_b = -K_ARM2RAD;
            end
            ST_PEN: begin
                w_a = OPND_W'(r_pen);
                w_b = -K_PEN2RAD;
            end
            ST_ERR_ARM: begin
                w_a = r_acc[OPND_W-1:0];
                w_b = K_ERRSCALE;
            end
            ST_ERR_PEN: begin
                w_a = r_t;
                w_b = K_ERRSCALE;
            end
            ST_T_OP: begin
                w_a = OPND_W'(r_gain_out_prev);
                w_b = OPND_W'(r_arm_out_prev);
            end
            ST_T_OP2: begin
                w_a = OPND_W'(r_gain_out_prev2);
                w_b = OPND_W'(r_arm_out_prev2);
            end
            ST_T_EN: begin
                w_a = OPND_W'(r_gain_err_now);
                w_b = OPND_W'(r_e_arm);
            end
            ST_T_EP: begin
                w_a = OPND_W'(r_gain_err_prev);
                w_b = OPND_W'(r_arm_err_prev);
            end
            ST_T_EP2: begin
                w_a = OPND_W'(r_gain_err_prev2);
                w_b = OPND_W'(r_arm_err_prev2);
            end
            ST_PEN_P: begin
                w_a = OPND_W'(r_gain_pendulum);
                w_b = OPND_W'(r_e_pen);
            end
            // The wide scalings are split into a signed high half and an
            // unsigned low 16 bits.
            ST_SCALE_HI: begin
                w_a = OPND_W'($signed(w_sum_sat[41:16]));
                w_b = K_ARMSCALE;
            end
            ST_SCALE_LO: begin
                w_a = {17'b0, w_sum_sat[15:0]};
                w_b = K_ARMSCALE;
            end
            ST_PSCALE_HI: begin
                w_a = OPND_W'($signed(r_p[34:16]));
                w_b = K_PENSCALE;
            end
            ST_PSCALE_LO: begin
                w_a = {17'b0, r_p[15:0]};
                w_b = K_PENSCALE;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    // Registered product of the shared multiplier.
    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_out_prev  <= '0;
            r_gain_out_prev2 <= '0;
            r_gain_err_now   <= '0;
            r_gain_err_prev  <= '0;
            r_gain_err_prev2 <= '0;
            r_gain_pendulum  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GAIN_OUT_PREV:  r_gain_out_prev  <= i_cfg_data;
                CFG_GAIN_OUT_PREV2: r_gain_out_prev2 <= i_cfg_data;
                CFG_GAIN_ERR_NOW:   r_gain_err_now   <= i_cfg_data;
                CFG_GAIN_ERR_PREV:  r_gain_err_prev  <= i_cfg_data;
                CFG_GAIN_ERR_PREV2: r_gain_err_prev2 <= i_cfg_data;
                CFG_GAIN_PENDULUM:  r_gain_pendulum  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: each step consumes the product issued in the step before.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_out_valid     <= 1'b0;
            r_arm_err_prev  <= '0;
            r_arm_err_prev2 <= '0;
            r_arm_out_prev  <= '0;
            r_arm_out_prev2 <= '0;
        end else begin
            // The final step refills the output register itself.
            if (r_out_valid && o_out.ready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_ref   <= i_in.ref_angle_deg;
                        r_arm   <= i_in.arm_count;
                        r_pen   <= i_in.pendulum_count;
                        r_state <= ST_REF;
                    end
                end
                ST_REF: r_state <= ST_ARM;
                ST_ARM: begin
                    r_acc   <= r_prod;
                    r_state <= ST_PEN;
                end
                ST_PEN: begin
                    r_acc   <= r_acc + r_prod;
                    r_state <= ST_ERR_ARM;
                end
                ST_ERR_ARM: begin
                    r_t     <= r_prod[OPND_W-1:0];
                    r_state <= ST_ERR_PEN;
                end
                ST_ERR_PEN: begin
                    r_e_arm <= w_rnd_prod[GAIN_W-1:0];
                    r_state <= ST_T_OP;
                end
                ST_T_OP: begin
                    r_e_pen <= w_rnd_prod[GAIN_W-1:0];
                    r_state <= ST_T_OP2;
                end
                ST_T_OP2: begin
                    r_acc   <= w_rnd_prod;
                    r_state <= ST_T_EN;
                end
                ST_T_EN: begin
                    r_acc   <= r_acc + w_rnd_prod;
                    r_state <= ST_T_EP;
                end
                ST_T_EP: begin
                    r_acc   <= r_acc + w_rnd_prod;
                    r_state <= ST_T_EP2;
                end
                ST_T_EP2: begin
                    r_acc   <= r_acc + w_rnd_prod;
                    r_state <= ST_PEN_P;
                end
                // The term two errors back is subtracted.
                ST_PEN_P: begin
                    r_acc   <= r_acc - w_rnd_prod;
                    r_state <= ST_SCALE_HI;
                end
                ST_SCALE_HI: begin
                    r_p     <= w_rnd_prod[34:0];
                    r_state <= ST_SCALE_LO;
                end
                ST_SCALE_LO: begin
                    r_acc   <= r_prod <<< 16;
                    r_state <= ST_PSCALE_HI;
                end
                ST_PSCALE_HI: begin
                    r_acc   <= r_acc + r_prod;
                    r_state <= ST_PSCALE_LO;
                end
                // Round and saturate the arm output, start the pendulum scale.
                ST_PSCALE_LO: begin
                    if (w_rnd_acc > K_INT32_MAX) begin
                        r_u1 <= K_INT32_MAX[GAIN_W-1:0];
                    end else if (w_rnd_acc < K_INT32_MIN) begin
                        r_u1 <= K_INT32_MIN[GAIN_W-1:0];
                    end else begin
                        r_u1 <= w_rnd_acc[GAIN_W-1:0];
                    end
                    r_acc   <= r_prod <<< 16;
                    r_state <= ST_U2_ACC;
                end
                ST_U2_ACC: begin
                    r_acc   <= r_acc + r_prod;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_acc   <= w_rnd_acc + PROD_W'(r_u1);
                    r_state <= ST_DONE;
                end
                // Clamp the negated sum and update the loop history.
                ST_DONE: begin
                    if (w_out_free) begin
                        if (r_acc > K_LIMIT) begin
                            r_drive   <= DRIVE_MIN;
                            r_clamped <= 1'b1;
                        end else if (r_acc < -K_LIMIT) begin
                            r_drive   <= DRIVE_MAX;
                            r_clamped <= 1'b1;
                        end else begin
                            r_drive   <= w_neg_acc[DRIVE_W-1:0];
                            r_clamped <= 1'b0;
                        end
                        r_out_valid     <= 1'b1;
                        r_arm_err_prev2 <= r_arm_err_prev;
                        r_arm_err_prev  <= r_e_arm;
                        r_arm_out_prev2 <= r_arm_out_prev;
                        r_arm_out_prev  <= r_u1;
                        r_state         <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready    = (r_state == ST_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.drive   = r_drive;
    assign o_out.clamped = r_clamped;

endmodule
